@@ rtl/mkne_pkg.sv @@
// ----------------------------------------------------------------------------
// mkne_pkg
// Types, codes and constants of the keypad number entry block.
// ----------------------------------------------------------------------------
`default_nettype none

package mkne_pkg;

  localparam int unsigned KeyLinesDef = 4;
  localparam int unsigned MaxCharsDef = 10;

  localparam int unsigned ColW     = 4;
  localparam int unsigned RowSelW  = 2;
  localparam int unsigned KeyW     = 4;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MantW    = 34;
  localparam int unsigned OutLenW  = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned LayoutN  = 4;

  // Divide-by-ten of the mantissa in two halves, each by exact reciprocal.
  localparam int unsigned HalfW        = MantW / 2;
  localparam int unsigned RemW         = 4;
  localparam int unsigned LowW         = HalfW + RemW;
  localparam int unsigned RecipHiShift = HalfW + 4;
  localparam int unsigned RecipHiW     = HalfW + 1;
  localparam int unsigned RecipLoShift = LowW + 4;
  localparam int unsigned RecipLoW     = LowW + 1;
  localparam longint unsigned RecipHi  = ((64'd1 << RecipHiShift) + 64'd9) / 64'd10;
  localparam longint unsigned RecipLo  = ((64'd1 << RecipLoShift) + 64'd9) / 64'd10;

  localparam logic [KeyW-1:0] KeyDigitMax = 4'd9;
  localparam logic [KeyW-1:0] KeyA        = 4'd10;
  localparam logic [KeyW-1:0] KeyB        = 4'd11;
  localparam logic [KeyW-1:0] KeyC        = 4'd12;
  localparam logic [KeyW-1:0] KeyD        = 4'd13;
  localparam logic [KeyW-1:0] KeyStar     = 4'd14;
  localparam logic [KeyW-1:0] KeyHash     = 4'd15;

  localparam logic [KeyW-1:0] KeyLayout [LayoutN][LayoutN] = '{
    '{4'd1,    4'd2, 4'd3,    KeyA},
    '{4'd4,    4'd5, 4'd6,    KeyB},
    '{4'd7,    4'd8, 4'd9,    KeyC},
    '{KeyStar, 4'd0, KeyHash, KeyD}
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgEntryMode    = 8'd0,
    CfgMaxLength    = 8'd1,
    CfgReleaseTicks = 8'd2
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    ModeInteger = 2'd0,
    ModeDecimal = 2'd1,
    ModeCancel  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ColW-1:0] column_levels;
  } col_beat_t;

  typedef struct packed {
    logic [RowSelW-1:0] row_select;
    logic               key_taken;
    logic [OutLenW-1:0] entry_length;
    logic [MantW-1:0]   entry_value;
    logic [OutLenW-1:0] fraction_digits;
    logic               has_point;
    logic               entry_done;
    logic               entry_cancelled;
  } res_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_beat_t;

endpackage

`default_nettype wire

@@ rtl/mkne_stream_if.sv @@
// ----------------------------------------------------------------------------
// mkne_stream_if
// Valid/ready channels of the keypad number entry block: column samples,
// results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkne_col_if import mkne_pkg::*; ();
  logic      valid;
  logic      ready;
  col_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mkne_res_if import mkne_pkg::*; ();
  logic      valid;
  logic      ready;
  res_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mkne_cfg_if import mkne_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/matrix_keypad_number_entry.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_number_entry
// Matrix keypad scanner with decimal number entry.
// ----------------------------------------------------------------------------
// Each beat on in_i is one column sample of the row named by the previous
// result's row_select; every beat gives exactly one result beat on out_o.
// The block takes one beat per cycle: a beat is registered, the scan and
// entry update run between that input register and the result register,
// so a result is valid on out_o once its beat has moved from the input
// register into the result register. While a result waits on out_o, the
// input register holds one more beat and then in_i stalls until the result
// is taken. Deleting a digit uses a divide-by-ten that is prepared in
// registers fed from the mantissa register, which is always in time because
// a key release is at least two beats after the previous one. Configuration
// writes on cfg_i are always ready and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_number_entry import mkne_pkg::*; #(
  parameter int unsigned KEY_LINES = KeyLinesDef,
  parameter int unsigned MAX_CHARS = MaxCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkne_col_if.sink   in_i,
  mkne_res_if.source out_o,
  mkne_cfg_if.sink   cfg_i
);

  localparam int unsigned RowW    = (KEY_LINES > 1) ? $clog2(KEY_LINES) : 1;
  localparam int unsigned RowExtW = (RowW > RowSelW) ? RowW : RowSelW;
  localparam int unsigned NumCols = (KEY_LINES < ColW) ? KEY_LINES : ColW;
  localparam int unsigned CharW   = $clog2(MAX_CHARS + 1);
  localparam int unsigned LenW    = (CharW > OutLenW) ? CharW : OutLenW;
  localparam logic [RowW-1:0] LastRow   = RowW'(KEY_LINES - 1);
  localparam logic [LenW-1:0] MaxCharsL = LenW'(MAX_CHARS);
  localparam int unsigned PhW = HalfW + RecipHiW;
  localparam int unsigned PlW = LowW + RecipLoW;

  // configuration
  logic [ModeW-1:0]    entry_mode_q;
  logic [OutLenW-1:0]  max_length_q;
  logic [CountW-1:0]   release_ticks_q;

  // pipeline
  logic                in_v_q, in_v_d;
  logic [ColW-1:0]     cols_q;
  logic                out_v_q, out_v_d;
  res_beat_t           res_q, res_d;
  logic                proc, in_ready;

  // scan and entry state
  logic [RowW-1:0]     row_q, row_d;
  logic                wait_q, wait_d;
  logic [1:0]          held_col_q, held_col_d;
  logic [KeyW-1:0]     held_key_q, held_key_d;
  logic [CountW-1:0]   high_cnt_q, high_cnt_d;
  logic [MantW-1:0]    mant_q, mant_d, mant_n;
  logic [CharW-1:0]    dcnt_q, dcnt_d, dcnt_n;
  logic                pt_q, pt_d, pt_n;
  logic [CharW-1:0]    ptpos_q, ptpos_d, ptpos_n;

  // divide by ten
  logic [HalfW-1:0]    mh, qh, qh_q, ml_q, ql;
  logic [HalfW-1:0]    rh_full;
  logic [RemW-1:0]     rh_q;
  logic [PhW-1:0]      prod_hi;
  logic [PlW-1:0]      prod_lo;
  logic [LowW-1:0]     low;
  logic [MantW-1:0]    mant_div10, mant_x10;

  // step logic
  logic                hit, taken, done, cancelled;
  logic [1:0]          hit_col;
  logic [RowExtW-1:0]  row_ext, row_ext_d;
  logic                row_in_layout;
  logic [LenW-1:0]     len_cur, len_n, frac_n, limit;
  logic [CountW-1:0]   need, cnt_inc;

  assign proc     = in_v_q && (!out_v_q || out_o.ready);
  assign in_ready = !in_v_q || proc;

  assign in_i.ready    = in_ready;
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_v_q;
  assign out_o.payload = res_q;

  assign in_v_d  = (in_i.valid && in_ready) ? 1'b1 : (proc ? 1'b0 : in_v_q);
  assign out_v_d = proc ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);

  // high half quotient and remainder, registered every cycle
  assign mh      = mant_q[MantW-1:HalfW];
  assign prod_hi = PhW'(mh) * PhW'(RecipHi);
  assign qh      = HalfW'(prod_hi >> RecipHiShift);
  assign rh_full = mh - ((qh << 3) + (qh << 1));

  // low part finishes the quotient
  assign low        = {rh_q, ml_q};
  assign prod_lo    = PlW'(low) * PlW'(RecipLo);
  assign ql         = HalfW'(prod_lo >> RecipLoShift);
  assign mant_div10 = {qh_q, ql};
  assign mant_x10   = (mant_q << 3) + (mant_q << 1);

  assign row_ext       = RowExtW'(row_q);
  assign row_in_layout = (32'(row_q) < 32'(LayoutN));

  always_comb begin
    row_d      = row_q;
    wait_d     = wait_q;
    held_col_d = held_col_q;
    held_key_d = held_key_q;
    high_cnt_d = high_cnt_q;
    mant_n     = mant_q;
    dcnt_n     = dcnt_q;
    pt_n       = pt_q;
    ptpos_n    = ptpos_q;
    taken      = 1'b0;
    done       = 1'b0;
    cancelled  = 1'b0;
    hit        = 1'b0;
    hit_col    = '0;
    for (int j = NumCols - 1; j >= 0; j--) begin
      if (!cols_q[j]) begin
        hit     = 1'b1;
        hit_col = 2'(j);
      end
    end
    len_cur = LenW'(dcnt_q) + LenW'(pt_q);
    limit   = (LenW'(max_length_q) > MaxCharsL) ? MaxCharsL : LenW'(max_length_q);
    need    = (release_ticks_q == '0) ? CountW'(1) : release_ticks_q;
    cnt_inc = (high_cnt_q == '1) ? high_cnt_q : high_cnt_q + 1'b1;

    if (!wait_q) begin
      if (hit) begin
        wait_d     = 1'b1;
        held_col_d = hit_col;
        held_key_d = row_in_layout ? KeyLayout[row_ext[1:0]][hit_col] : KeyHash;
        high_cnt_d = '0;
      end else begin
        row_d = (row_q == LastRow) ? '0 : row_q + 1'b1;
      end
    end else if (!cols_q[held_col_q]) begin
      high_cnt_d = '0;
    end else begin
      high_cnt_d = cnt_inc;
      if (cnt_inc >= need) begin
        taken      = 1'b1;
        wait_d     = 1'b0;
        high_cnt_d = '0;
        row_d      = '0;
        if (held_key_q == KeyA || len_cur >= limit) begin
          done = 1'b1;
        end else if (held_key_q == KeyStar && entry_mode_q == ModeCancel) begin
          done      = 1'b1;
          cancelled = 1'b1;
        end else if (held_key_q <= KeyDigitMax) begin
          mant_n = mant_x10 + MantW'(held_key_q);
          dcnt_n = dcnt_q + 1'b1;
        end else if (held_key_q == KeyD) begin
          if (len_cur != '0) begin
            if (pt_q && ptpos_q == dcnt_q) begin
              pt_n    = 1'b0;
              ptpos_n = '0;
            end else if (dcnt_q != '0) begin
              mant_n = mant_div10;
              dcnt_n = dcnt_q - 1'b1;
            end
          end
        end else if (held_key_q == KeyStar && entry_mode_q == ModeDecimal) begin
          if (!pt_q) begin
            pt_n    = 1'b1;
            ptpos_n = dcnt_q;
          end
        end
      end
    end

    len_n     = LenW'(dcnt_n) + LenW'(pt_n);
    frac_n    = pt_n ? LenW'(dcnt_n - ptpos_n) : '0;
    row_ext_d = RowExtW'(row_d);

    res_d.row_select      = row_ext_d[RowSelW-1:0];
    res_d.key_taken       = taken;
    res_d.entry_done      = done;
    res_d.entry_cancelled = cancelled;
    res_d.entry_length    = cancelled ? '0 : len_n[OutLenW-1:0];
    res_d.entry_value     = cancelled ? '0 : mant_n;
    res_d.fraction_digits = cancelled ? '0 : frac_n[OutLenW-1:0];
    res_d.has_point       = cancelled ? 1'b0 : pt_n;

    mant_d  = done ? '0 : mant_n;
    dcnt_d  = done ? '0 : dcnt_n;
    pt_d    = done ? 1'b0 : pt_n;
    ptpos_d = done ? '0 : ptpos_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_mode_q    <= ModeInteger;
      max_length_q    <= OutLenW'(10);
      release_ticks_q <= CountW'(1);
    end else if (cfg_i.valid) begin
      if (cfg_i.payload.index == CfgEntryMode) begin
        entry_mode_q <= cfg_i.payload.data[ModeW-1:0];
      end else if (cfg_i.payload.index == CfgMaxLength) begin
        max_length_q <= cfg_i.payload.data[OutLenW-1:0];
      end else if (cfg_i.payload.index == CfgReleaseTicks) begin
        release_ticks_q <= cfg_i.payload.data[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      row_q      <= '0;
      wait_q     <= 1'b0;
      held_col_q <= '0;
      held_key_q <= '0;
      high_cnt_q <= '0;
      mant_q     <= '0;
      dcnt_q     <= '0;
      pt_q       <= 1'b0;
      ptpos_q    <= '0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (proc) begin
        row_q      <= row_d;
        wait_q     <= wait_d;
        held_col_q <= held_col_d;
        held_key_q <= held_key_d;
        high_cnt_q <= high_cnt_d;
        mant_q     <= mant_d;
        dcnt_q     <= dcnt_d;
        pt_q       <= pt_d;
        ptpos_q    <= ptpos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qh_q <= qh;
    rh_q <= rh_full[RemW-1:0];
    ml_q <= mant_q[HalfW-1:0];
    if (in_i.valid && in_ready) begin
      cols_q <= in_i.payload.column_levels;
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  a_taken_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.key_taken |-> out_o.payload.row_select == '0)
    else $error("key taken without scan restart");

  a_cancel_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.entry_cancelled |->
      out_o.payload.entry_done && out_o.payload.entry_value == '0 &&
      out_o.payload.entry_length == '0)
    else $error("cancel beat carries entry data");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_cur <= MaxCharsL)
    else $error("entry length beyond limit");

  a_release_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && taken |=> !wait_q)
    else $error("still waiting for release after key taken");

endmodule

`default_nettype wire
